// ===== hw/rtl/lhrb_pkg.sv =====
package lhrb_pkg;

  localparam int unsigned LINE_SLOTS_DEF = 128;
  localparam int unsigned LINE_WIDTH_DEF = 64;

  localparam int unsigned OP_W    = 2;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned IDX_W   = 7;
  localparam int unsigned COUNT_W = 8;

  // Depths of the command queue and the result queue
  localparam int unsigned CMD_DEPTH = 4;
  localparam int unsigned RES_DEPTH = 4;

  localparam logic [OP_W-1:0] OP_PUSH  = 2'd0;
  localparam logic [OP_W-1:0] OP_READ  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  localparam logic [BYTE_W-1:0] CHAR_NL  = 8'd10;
  localparam logic [BYTE_W-1:0] CHAR_NUL = 8'd0;

  typedef enum logic [1:0] {
    CMD_PUSH,
    CMD_CLOSE,
    CMD_CLEAR,
    CMD_READ
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e           kind;
    logic [BYTE_W-1:0]   data_byte;
    logic [IDX_W-1:0]    line_index;
  } cmd_t;

  typedef struct packed {
    logic [BYTE_W-1:0]   char_out;
    logic                found;
    logic                last;
    logic [COUNT_W-1:0]  line_count;
  } result_t;

  typedef enum logic [2:0] {
    BK_INIT,
    BK_IDLE,
    BK_CLOSE,
    BK_MAP,
    BK_LEN,
    BK_BYTES
  } back_state_e;

endpackage

// ===== hw/rtl/lhrb_ram.sv =====
module lhrb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== hw/rtl/lhrb_fifo.sv =====
module lhrb_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic [WIDTH-1:0]           wdata_i,
  input  logic                       pop_i,
  output logic [WIDTH-1:0]           rdata_o,
  output logic                       empty_o,
  output logic [$clog2(DEPTH+1)-1:0] count_o
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             is_full;
  logic             do_push;
  logic             do_pop;

  assign empty_o = (count_q == '0);
  assign is_full = (count_q == CNT_W'(DEPTH));
  assign count_o = count_q;
  assign rdata_o = slots_q[rd_ptr_q];

  assign do_push = push_i & ~is_full;
  assign do_pop  = pop_i & ~empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

// ===== hw/rtl/lhrb_front.sv =====
module lhrb_front (
  input  logic                               push,
  input  logic [lhrb_pkg::OP_W-1:0]          operation_i,
  input  logic [lhrb_pkg::BYTE_W-1:0]        data_byte_i,
  input  logic [lhrb_pkg::IDX_W-1:0]         line_index_i,
  input  logic                               queue_full_i,
  input  logic                               back_ready_i,
  output logic                               full,
  output logic                               cmd_push_o,
  output lhrb_pkg::cmd_t                     cmd_o
);

  logic known_op;

  assign full = queue_full_i | ~back_ready_i;

  // Classify the transaction; a line terminator becomes its own command
  always_comb begin
    cmd_o.data_byte  = data_byte_i;
    cmd_o.line_index = line_index_i;
    cmd_o.kind       = lhrb_pkg::CMD_PUSH;
    known_op         = 1'b1;
    case (operation_i)
      lhrb_pkg::OP_PUSH: begin
        if (data_byte_i inside {lhrb_pkg::CHAR_NL, lhrb_pkg::CHAR_NUL}) begin
          cmd_o.kind = lhrb_pkg::CMD_CLOSE;
        end else begin
          cmd_o.kind = lhrb_pkg::CMD_PUSH;
        end
      end
      lhrb_pkg::OP_READ: begin
        cmd_o.kind = lhrb_pkg::CMD_READ;
      end
      lhrb_pkg::OP_CLEAR: begin
        cmd_o.kind = lhrb_pkg::CMD_CLEAR;
      end
      default: begin
        known_op = 1'b0;
      end
    endcase
  end

  // Drop unused codes: accepted, but nothing reaches the back end
  assign cmd_push_o = push & ~full & known_op;

endmodule

// ===== hw/rtl/lhrb_back.sv =====
module lhrb_back #(
  parameter int unsigned LINE_SLOTS = lhrb_pkg::LINE_SLOTS_DEF,
  parameter int unsigned LINE_WIDTH = lhrb_pkg::LINE_WIDTH_DEF
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  logic                                         cmd_empty_i,
  input  lhrb_pkg::cmd_t                               cmd_i,
  output logic                                         cmd_pop_o,
  input  logic [$clog2(lhrb_pkg::RES_DEPTH+1)-1:0]     res_count_i,
  output logic                                         res_push_o,
  output lhrb_pkg::result_t                            res_o,
  output logic                                         ready_o
);

  localparam int unsigned SW      = $clog2(LINE_SLOTS);
  localparam int unsigned HW      = $clog2(LINE_SLOTS + 1);
  localparam int unsigned PW      = $clog2(LINE_SLOTS + 1);
  localparam int unsigned LEN_W   = $clog2(LINE_WIDTH);
  localparam int unsigned ROWS    = LINE_SLOTS + 1;
  localparam int unsigned ST_DEPTH = ROWS << LEN_W;
  localparam int unsigned ST_AW   = $clog2(ST_DEPTH);
  localparam int unsigned RC_W    = $clog2(lhrb_pkg::RES_DEPTH + 1);
  localparam int unsigned CMP_W   = (HW > lhrb_pkg::IDX_W) ? HW : lhrb_pkg::IDX_W;
  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(LINE_WIDTH - 1);

  lhrb_pkg::back_state_e state_q, state_d;

  logic [SW-1:0]    oldest_q, oldest_d;
  logic [HW-1:0]    held_q, held_d;
  logic [LEN_W-1:0] plen_q, plen_d;
  logic [PW-1:0]    free_q, free_d;
  logic [SW-1:0]    init_q, init_d;
  logic             pend_q, pend_d;
  logic [SW-1:0]    slot_q, slot_d;
  logic [PW-1:0]    phys_q, phys_d;
  logic [LEN_W-1:0] len_q, len_d;
  logic [LEN_W-1:0] k_q, k_d;
  logic             pend_nf_q, pend_nf_d;
  logic             pend_last_q, pend_last_d;

  logic             map_we;
  logic [SW-1:0]    map_waddr;
  logic [PW-1:0]    map_wdata;
  logic [SW-1:0]    map_raddr;
  logic [PW-1:0]    map_rdata;
  logic             len_we;
  logic [PW-1:0]    len_raddr;
  logic [LEN_W-1:0] len_rdata;
  logic             st_we;
  logic [ST_AW-1:0] st_waddr;
  logic [ST_AW-1:0] st_raddr;
  logic [lhrb_pkg::BYTE_W-1:0] st_rdata;

  logic             credit;
  logic             take;
  logic             found;
  logic             ring_full;
  logic             last_byte;
  logic [SW:0]      read_sum;
  logic [SW-1:0]    read_slot;
  logic [SW:0]      fill_sum;
  logic [SW-1:0]    fill_slot;
  logic [SW-1:0]    close_slot;
  logic [SW-1:0]    oldest_next;

  // One result may still be in flight from the store, so count it as taken
  assign credit = ({1'b0, res_count_i} + (RC_W + 1)'(pend_q))
                  < (RC_W + 1)'(lhrb_pkg::RES_DEPTH);

  assign take = (state_q == lhrb_pkg::BK_IDLE) && !cmd_empty_i &&
                ((cmd_i.kind != lhrb_pkg::CMD_READ) || credit);

  assign found     = CMP_W'(cmd_i.line_index) < CMP_W'(held_q);
  assign ring_full = (held_q == HW'(LINE_SLOTS));
  assign last_byte = (LEN_W'(k_q + 1'b1) == len_q);

  assign read_sum  = {1'b0, oldest_q} + {1'b0, SW'(cmd_i.line_index)};
  assign read_slot = (read_sum >= (SW + 1)'(LINE_SLOTS)) ?
                     SW'(read_sum - (SW + 1)'(LINE_SLOTS)) : SW'(read_sum);
  assign fill_sum  = {1'b0, oldest_q} + (SW + 1)'(held_q);
  assign fill_slot = (fill_sum >= (SW + 1)'(LINE_SLOTS)) ?
                     SW'(fill_sum - (SW + 1)'(LINE_SLOTS)) : SW'(fill_sum);
  assign close_slot = ring_full ? oldest_q : fill_slot;
  assign oldest_next = (oldest_q == SW'(LINE_SLOTS - 1)) ? '0 : oldest_q + 1'b1;

  always_comb begin
    state_d = state_q;
    case (state_q)
      lhrb_pkg::BK_INIT: begin
        if (init_q == SW'(LINE_SLOTS - 1)) begin
          state_d = lhrb_pkg::BK_IDLE;
        end
      end
      lhrb_pkg::BK_IDLE: begin
        if (take) begin
          if (cmd_i.kind == lhrb_pkg::CMD_CLOSE && plen_q != '0) begin
            state_d = lhrb_pkg::BK_CLOSE;
          end else if (cmd_i.kind == lhrb_pkg::CMD_READ && found) begin
            state_d = lhrb_pkg::BK_MAP;
          end
        end
      end
      lhrb_pkg::BK_CLOSE: state_d = lhrb_pkg::BK_IDLE;
      lhrb_pkg::BK_MAP:   state_d = lhrb_pkg::BK_LEN;
      lhrb_pkg::BK_LEN:   state_d = lhrb_pkg::BK_BYTES;
      lhrb_pkg::BK_BYTES: begin
        if (credit && last_byte) begin
          state_d = lhrb_pkg::BK_IDLE;
        end
      end
      default: state_d = lhrb_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    oldest_d    = oldest_q;
    held_d      = held_q;
    plen_d      = plen_q;
    free_d      = free_q;
    init_d      = init_q;
    pend_d      = 1'b0;
    slot_d      = slot_q;
    phys_d      = phys_q;
    len_d       = len_q;
    k_d         = k_q;
    pend_nf_d   = pend_nf_q;
    pend_last_d = pend_last_q;
    cmd_pop_o   = 1'b0;
    map_we      = 1'b0;
    map_waddr   = slot_q;
    map_wdata   = free_q;
    map_raddr   = close_slot;
    len_we      = 1'b0;
    len_raddr   = map_rdata;
    st_we       = 1'b0;
    st_waddr    = {free_q, plen_q};
    st_raddr    = {phys_q, k_q};
    case (state_q)
      lhrb_pkg::BK_INIT: begin
        // Map every line slot to the row of the same number
        map_we    = 1'b1;
        map_waddr = init_q;
        map_wdata = PW'(init_q);
        init_d    = init_q + 1'b1;
      end
      lhrb_pkg::BK_IDLE: begin
        if (take) begin
          cmd_pop_o = 1'b1;
          case (cmd_i.kind)
            lhrb_pkg::CMD_PUSH: begin
              // Write straight into the spare row; drop bytes past LINE_WIDTH-1
              if (plen_q < MAX_LEN) begin
                st_we  = 1'b1;
                plen_d = plen_q + 1'b1;
              end
            end
            lhrb_pkg::CMD_CLOSE: begin
              plen_d = '0;
              if (plen_q != '0) begin
                map_raddr = close_slot;
                slot_d    = close_slot;
                len_we    = 1'b1;
                if (ring_full) begin
                  oldest_d = oldest_next;
                end else begin
                  held_d = held_q + 1'b1;
                end
              end
            end
            lhrb_pkg::CMD_CLEAR: begin
              oldest_d = '0;
              held_d   = '0;
            end
            lhrb_pkg::CMD_READ: begin
              map_raddr = read_slot;
              if (!found) begin
                pend_d      = 1'b1;
                pend_nf_d   = 1'b1;
                pend_last_d = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end
      lhrb_pkg::BK_CLOSE: begin
        // Swap the spare row into the slot; the displaced row becomes spare
        map_we = 1'b1;
        free_d = map_rdata;
      end
      lhrb_pkg::BK_MAP: begin
        len_raddr = map_rdata;
        phys_d    = map_rdata;
      end
      lhrb_pkg::BK_LEN: begin
        len_d = len_rdata;
        k_d   = '0;
      end
      lhrb_pkg::BK_BYTES: begin
        if (credit) begin
          pend_d      = 1'b1;
          pend_nf_d   = 1'b0;
          pend_last_d = last_byte;
          k_d         = k_q + 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  assign ready_o    = (state_q != lhrb_pkg::BK_INIT);
  assign res_push_o = pend_q;

  always_comb begin
    res_o.char_out   = pend_nf_q ? '0 : st_rdata;
    res_o.found      = ~pend_nf_q;
    res_o.last       = pend_last_q;
    res_o.line_count = lhrb_pkg::COUNT_W'(held_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= lhrb_pkg::BK_INIT;
      oldest_q <= '0;
      held_q   <= '0;
      plen_q   <= '0;
      free_q   <= PW'(LINE_SLOTS);
      init_q   <= '0;
      pend_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      oldest_q <= oldest_d;
      held_q   <= held_d;
      plen_q   <= plen_d;
      free_q   <= free_d;
      init_q   <= init_d;
      pend_q   <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q      <= slot_d;
    phys_q      <= phys_d;
    len_q       <= len_d;
    k_q         <= k_d;
    pend_nf_q   <= pend_nf_d;
    pend_last_q <= pend_last_d;
  end

  lhrb_ram #(
    .WIDTH (PW),
    .DEPTH (LINE_SLOTS)
  ) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (map_we),
    .waddr_i (map_waddr),
    .wdata_i (map_wdata),
    .raddr_i (map_raddr),
    .rdata_o (map_rdata)
  );

  lhrb_ram #(
    .WIDTH (LEN_W),
    .DEPTH (ROWS)
  ) u_len_ram (
    .clk_i   (clk_i),
    .we_i    (len_we),
    .waddr_i (free_q),
    .wdata_i (plen_q),
    .raddr_i (len_raddr),
    .rdata_o (len_rdata)
  );

  lhrb_ram #(
    .WIDTH (lhrb_pkg::BYTE_W),
    .DEPTH (ST_DEPTH)
  ) u_store_ram (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (cmd_i.data_byte),
    .raddr_i (st_raddr),
    .rdata_o (st_rdata)
  );

endmodule

// ===== hw/rtl/line_history_ring_buffer.sv =====
// Scrollback store of text lines, seen as a queue on both sides.
// Input channel: push/full carry one transaction of operation_i, data_byte_i
// and line_index_i. Operation push appends a byte to the open line (bytes past
// LINE_WIDTH-1 are dropped), and a newline or zero byte closes it; a non-empty
// line lands in a ring of LINE_SLOTS lines, overwriting the oldest when full.
// Read returns the named line, counted from the oldest, one byte per result,
// or a single not-found result. Clear empties the ring; the open line stays.
// Result channel: empty/pop; every result carries the current line count.
// The back end takes a byte push, a clear or a not-found read in its idle
// state; a line close adds a state that swaps the map entry, and a found
// read steps through the map, length and byte states, one byte per cycle
// out of the line store RAM while the result queue has room.
// After reset the back end runs a pass over the LINE_SLOTS slots that sets
// up the slot-to-row map; full stays high until it ends. When the receiver
// stalls, the result queue fills, the back end holds, and the command queue
// then raises full.
module line_history_ring_buffer #(
  parameter int unsigned LINE_SLOTS = lhrb_pkg::LINE_SLOTS_DEF,
  parameter int unsigned LINE_WIDTH = lhrb_pkg::LINE_WIDTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              push,
  output logic                              full,
  input  logic [lhrb_pkg::OP_W-1:0]         operation_i,
  input  logic [lhrb_pkg::BYTE_W-1:0]       data_byte_i,
  input  logic [lhrb_pkg::IDX_W-1:0]        line_index_i,
  output logic                              empty,
  input  logic                              pop,
  output logic [lhrb_pkg::BYTE_W-1:0]       char_out_o,
  output logic                              found_o,
  output logic                              last_o,
  output logic [lhrb_pkg::COUNT_W-1:0]      line_count_o
);

  localparam int unsigned RC_W = $clog2(lhrb_pkg::RES_DEPTH + 1);
  localparam int unsigned CC_W = $clog2(lhrb_pkg::CMD_DEPTH + 1);

  // Front end to command queue
  logic              cmd_push;
  lhrb_pkg::cmd_t    cmd_in;
  logic              cmd_full;

  // Command queue to back end
  lhrb_pkg::cmd_t    cmd_head;
  logic              cmd_empty;
  logic              cmd_pop;
  logic [CC_W-1:0]   cmd_count;

  logic              back_ready;

  // Back end to result queue
  logic              res_push;
  lhrb_pkg::result_t res_in;
  lhrb_pkg::result_t res_head;
  logic [RC_W-1:0]   res_count;

  // Classify each transaction; unused operation codes are taken and dropped
  lhrb_front u_front (
    .push         (push),
    .operation_i  (operation_i),
    .data_byte_i  (data_byte_i),
    .line_index_i (line_index_i),
    .queue_full_i (cmd_full),
    .back_ready_i (back_ready),
    .full         (full),
    .cmd_push_o   (cmd_push),
    .cmd_o        (cmd_in)
  );

  // Decouple: up to CMD_DEPTH pushes queue while the back end streams a read out
  lhrb_fifo #(
    .WIDTH ($bits(lhrb_pkg::cmd_t)),
    .DEPTH (lhrb_pkg::CMD_DEPTH)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .wdata_i (cmd_in),
    .pop_i   (cmd_pop),
    .rdata_o (cmd_head),
    .empty_o (cmd_empty),
    .count_o (cmd_count)
  );

  // Stall the front end once every command entry is taken
  assign cmd_full = (cmd_count == CC_W'(lhrb_pkg::CMD_DEPTH));

  // Execute commands in order against the line store
  lhrb_back #(
    .LINE_SLOTS (LINE_SLOTS),
    .LINE_WIDTH (LINE_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_empty_i (cmd_empty),
    .cmd_i       (cmd_head),
    .cmd_pop_o   (cmd_pop),
    .res_count_i (res_count),
    .res_push_o  (res_push),
    .res_o       (res_in),
    .ready_o     (back_ready)
  );

  // Hold results until the receiver pops them; the back end only pushes
  // when it has reserved room, so every push finds a free entry
  lhrb_fifo #(
    .WIDTH ($bits(lhrb_pkg::result_t)),
    .DEPTH (lhrb_pkg::RES_DEPTH)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res_in),
    .pop_i   (pop),
    .rdata_o (res_head),
    .empty_o (empty),
    .count_o (res_count)
  );

  assign char_out_o   = res_head.char_out;
  assign found_o      = res_head.found;
  assign last_o       = res_head.last;
  assign line_count_o = res_head.line_count;

endmodule
